/* rtl/cet_pkg.sv */
`default_nettype none
package cet_pkg;
    typedef enum logic [1:0] {
        K_TOUCH   = 2'd0,
        K_SAMPLE  = 2'd1,
        K_COLLECT = 2'd2,
        K_REAP    = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_FOUND = 2'd0,
        ST_NEW   = 2'd1,
        ST_FULL  = 2'd2,
        ST_SWEPT = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_READ,
        S_APPLY,
        S_OUT
    } t_state;

    localparam logic [1:0] CFG_BAND  = 2'd0;
    localparam logic [1:0] CFG_FLOOR = 2'd1;
    localparam logic [1:0] CFG_LIMIT = 2'd2;

    localparam logic [39:0] MAX40 = 40'hFF_FFFF_FFFF;

    // controller commands to the datapath
    typedef struct packed {
        logic load;     // capture input beat
        logic clr_scan; // reset scan index and match flags
        logic step;     // examine one slot
        logic rd;       // read matched or free slot
        logic apply;    // write back slot
        logic show;     // load output register
    } t_cmd;

    // datapath status to the controller
    typedef struct packed {
        logic scan_last;
        logic is_reap;
    } t_sts;
endpackage
`default_nettype wire

/* rtl/cet_ctrl.sv */
`default_nettype none
module cet_ctrl (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_ready,
    input  wire logic         i_out_busy,
    input  wire cet_pkg::t_sts i_sts,
    output cet_pkg::t_cmd     o_cmd
);
    import cet_pkg::*;

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load     = 1'b1;
                    o_cmd.clr_scan = 1'b1;
                    n_state        = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = i_sts.is_reap ? S_OUT : S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_APPLY;
            end
            S_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state     = S_OUT;
            end
            S_OUT: begin
                if (!i_out_busy) begin
                    o_cmd.show = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

/* rtl/cet_dpath.sv */
`default_nettype none
module cet_dpath #(
    parameter int MAX_CLIENTS = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire cet_pkg::t_cmd i_cmd,
    output cet_pkg::t_sts      o_sts,
    input  wire logic [1:0]    i_kind,
    input  wire logic [47:0]   i_mac,
    input  wire logic [39:0]   i_now,
    input  wire logic signed [15:0] i_metric,
    input  wire logic signed [15:0] i_band,
    input  wire logic [23:0]   i_floor,
    input  wire logic [23:0]   i_limit,
    output logic [1:0]         o_status,
    output logic [4:0]         o_slot,
    output logic [31:0]        o_count,
    output logic [39:0]        o_dur
);
    import cet_pkg::*;

    localparam int IW = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;

    // per-slot valid bits in flops, payload in memories
    logic [MAX_CLIENTS-1:0] r_valid;
    logic [47:0] mem_mac  [MAX_CLIENTS];
    logic [39:0] mem_seen [MAX_CLIENTS];
    logic [39:0] mem_open [MAX_CLIENTS];
    logic [31:0] mem_cnt  [MAX_CLIENTS];
    logic [39:0] mem_tot  [MAX_CLIENTS];

    logic [1:0]        r_kind;
    logic [47:0]       r_mac;
    logic [39:0]       r_now;
    logic signed [15:0] r_metric;
    logic [IW-1:0]     r_idx;
    logic              r_hit, r_free_ok;
    logic [IW-1:0]     r_hit_idx, r_free_idx;
    logic [47:0]       r_rd_mac;
    logic [39:0]       r_rd_seen;
    logic              r_rd_ok;
    logic [39:0]       r_open, r_tot;
    logic [31:0]       r_cnt;
    logic [IW-1:0]     r_sel;
    logic              r_new;

    logic [IW-1:0] scan_idx;
    logic          scan_last;
    logic          rd_valid;
    logic          is_match, is_stale;
    logic [40:0]   age;

    assign scan_last = (r_idx == IW'(MAX_CLIENTS - 1));
    assign o_sts.scan_last = scan_last && r_rd_ok;
    assign o_sts.is_reap   = (r_kind == K_REAP);

    // scan pipeline: address stage then compare stage
    always_ff @(posedge i_clk) begin
        r_rd_mac  <= mem_mac[scan_idx];
        r_rd_seen <= mem_seen[scan_idx];
    end
    assign scan_idx = r_idx;

    assign age      = {1'b0, r_now} - {1'b0, r_rd_seen};
    assign rd_valid = r_valid[r_idx];
    assign is_match = rd_valid && (r_rd_mac == r_mac);
    assign is_stale = rd_valid && !age[40] && (age[39:0] > {16'd0, i_limit});

    // input capture and scan control; r_rd_ok marks read data present
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_idx   <= '0;
            r_rd_ok <= 1'b0;
            r_hit   <= 1'b0;
            r_free_ok <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_kind   <= i_kind;
                r_mac    <= i_mac;
                r_now    <= i_now;
                r_metric <= i_metric;
            end
            if (i_cmd.clr_scan) begin
                r_idx     <= '0;
                r_rd_ok   <= 1'b0;
                r_hit     <= 1'b0;
                r_free_ok <= 1'b0;
            end else if (i_cmd.step) begin
                if (!r_rd_ok) begin
                    r_rd_ok <= 1'b1;
                end else begin
                    if (r_kind == K_REAP) begin
                        if (is_stale) r_valid[r_idx] <= 1'b0;
                    end else begin
                        if (!r_hit && is_match) begin
                            r_hit     <= 1'b1;
                            r_hit_idx <= r_idx;
                        end
                        if (!r_free_ok && !rd_valid) begin
                            r_free_ok  <= 1'b1;
                            r_free_idx <= r_idx;
                        end
                    end
                    r_rd_ok <= 1'b0;
                    if (!scan_last) r_idx <= r_idx + 1'b1;
                end
            end
            if (i_cmd.rd) begin
                r_sel <= r_hit ? r_hit_idx : r_free_idx;
                r_new <= !r_hit;
            end
            if (i_cmd.apply && (r_hit || r_free_ok) && r_new) begin
                r_valid[r_sel] <= 1'b1;
            end
        end
    end

    // slot read for the apply step
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_open <= mem_open[r_hit ? r_hit_idx : r_free_idx];
            r_cnt  <= mem_cnt[r_hit ? r_hit_idx : r_free_idx];
            r_tot  <= mem_tot[r_hit ? r_hit_idx : r_free_idx];
        end
    end

    // slot update arithmetic
    logic [39:0] open_b, open_n, tot_b, tot_n;
    logic [31:0] cnt_b, cnt_n;
    logic [40:0] elapsed, tsum;
    logic        do_wr;

    always_comb begin
        open_b = r_new ? 40'd0 : r_open;
        cnt_b  = r_new ? 32'd0 : r_cnt;
        tot_b  = r_new ? 40'd0 : r_tot;
        open_n = open_b;
        cnt_n  = cnt_b;
        tot_n  = tot_b;
        elapsed = {1'b0, r_now} - {1'b0, open_b};
        tsum    = {1'b0, tot_b} + {1'b0, elapsed[39:0]};
        case (r_kind)
            K_SAMPLE: begin
                if (r_metric < i_band) begin
                    if (open_b == 40'd0) begin
                        open_n = r_now;
                        cnt_n  = cnt_b + 32'd1;
                    end
                end else if (open_b != 40'd0) begin
                    if (!elapsed[40] && elapsed[39:0] >= {16'd0, i_floor}) begin
                        tot_n = tsum[40] ? MAX40 : tsum[39:0];
                    end
                    open_n = 40'd0;
                end
            end
            K_COLLECT: begin
                cnt_n = 32'd0;
                tot_n = 40'd0;
            end
            default: ;
        endcase
    end

    assign do_wr = i_cmd.apply && (r_hit || r_free_ok);

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            if (r_new) mem_mac[r_sel] <= r_mac;
            mem_seen[r_sel] <= r_now;
            mem_open[r_sel] <= open_n;
            mem_cnt[r_sel]  <= cnt_n;
            mem_tot[r_sel]  <= tot_n;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.show) begin
            o_count <= 32'd0;
            o_dur   <= 40'd0;
            o_slot  <= 5'd0;
            if (r_kind == K_REAP) begin
                o_status <= ST_SWEPT;
            end else if (!r_hit && !r_free_ok) begin
                o_status <= ST_FULL;
            end else begin
                o_status <= r_new ? ST_NEW : ST_FOUND;
                o_slot   <= 5'(r_sel);
                if (r_kind == K_COLLECT) begin
                    o_count <= r_new ? 32'd0 : r_cnt;
                    o_dur   <= r_new ? 40'd0 : r_tot;
                end
            end
        end
    end
endmodule
`default_nettype wire

/* rtl/client_excursion_tracker_core.sv */
`default_nettype none
// channel  | dir | beat contents
// s_axis   | in  | tdata: client_mac[47:0], now_ms[87:48], metric[103:88]; tuser: kind
// m_axis   | out | tdata: slot[4:0], excursion_count[36:5], excursion_time[76:37]; tuser: status
// cfg      | in  | index 0 band_level, 1 min_excursion, 2 absence_limit_ms
// one item at a time; lookup and reap walk every slot, and each slot takes a read
// step and then a compare step, since the slot memory read port is registered
// reset clears valid bits and registers; no clearing pass
// a result waits in the output register while the next item is worked;
// that item holds in its last step until the register is free
module client_excursion_tracker_core #(
    parameter int MAX_CLIENTS = 32
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [103:0] s_axis_tdata,  // client_mac, now_ms, metric
    input  wire logic [1:0]   s_axis_tuser,  // kind
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [79:0]       m_axis_tdata,  // slot, excursion_count, excursion_time, pad
    output logic [1:0]        m_axis_tuser,  // status
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [1:0]   i_cfg_index,
    input  wire logic [31:0]  i_cfg_data
);
    import cet_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic signed [15:0] r_band;
    logic [23:0] r_floor, r_limit;
    logic        r_out_v;
    logic [1:0]  st;
    logic [4:0]  slot;
    logic [31:0] cnt;
    logic [39:0] dur;

    // configuration registers
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band  <= '0;
            r_floor <= '0;
            r_limit <= 24'd60000;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BAND:  r_band  <= i_cfg_data[15:0];
                CFG_FLOOR: r_floor <= i_cfg_data[23:0];
                CFG_LIMIT: r_limit <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (cmd.show) begin
            r_out_v <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_v <= 1'b0;
        end
    end

    cet_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_out_busy (r_out_v && !m_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    cet_dpath #(.MAX_CLIENTS(MAX_CLIENTS)) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .i_kind   (s_axis_tuser),
        .i_mac    (s_axis_tdata[47:0]),
        .i_now    (s_axis_tdata[87:48]),
        .i_metric (s_axis_tdata[103:88]),
        .i_band   (r_band),
        .i_floor  (r_floor),
        .i_limit  (r_limit),
        .o_status (st),
        .o_slot   (slot),
        .o_count  (cnt),
        .o_dur    (dur)
    );

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tuser  = st;
    assign m_axis_tdata  = {3'd0, dur, cnt, slot};
endmodule
`default_nettype wire
